// ----- rtl/sprite_mvp_matrix_builder_assert.svh -----
// Assertion macros for the sprite matrix builder.
`ifndef SPRITE_MVP_MATRIX_BUILDER_ASSERT_SVH
`define SPRITE_MVP_MATRIX_BUILDER_ASSERT_SVH
// Check an implication in the same cycle.
`define SMVP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Check an implication in the cycle after the antecedent.
`define SMVP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/smvp_pkg.sv -----
// Shared types, constants and tables of the sprite matrix builder.
package smvp_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int RED_STAGES   = 14;
  localparam int XW           = 33;
  localparam int ZW           = 33;
  localparam int DIV_BITS     = 48;

  localparam logic [18:0] TWO_PI   = 19'd411775;
  localparam logic [18:0] PI       = 19'd205887;
  localparam logic [18:0] HALF_PI  = 19'd102944;
  localparam logic [18:0] OFF_MOD  = 19'd77023;
  localparam logic [29:0] GAIN     = 30'd652032874;
  localparam logic [30:0] SCALE_RST = 31'd65536;

  typedef enum logic [2:0] {
    CFG_CAMERA_X    = 3'd0,
    CFG_CAMERA_Y    = 3'd1,
    CFG_VIEW_WIDTH  = 3'd2,
    CFG_VIEW_HEIGHT = 3'd3,
    CFG_ZOOM_FACTOR = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;
  } cordic_t;

  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [31:0] scx;
    logic signed [31:0] scy;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 33'sd843314857;
      5'd1:  v = 33'sd497837829;
      5'd2:  v = 33'sd263043837;
      5'd3:  v = 33'sd133525159;
      5'd4:  v = 33'sd67021687;
      5'd5:  v = 33'sd33543516;
      5'd6:  v = 33'sd16775851;
      5'd7:  v = 33'sd8388437;
      5'd8:  v = 33'sd4194283;
      5'd9:  v = 33'sd2097149;
      5'd10: v = 33'sd1048576;
      5'd11: v = 33'sd524288;
      5'd12: v = 33'sd262144;
      5'd13: v = 33'sd131072;
      5'd14: v = 33'sd65536;
      5'd15: v = 33'sd32768;
      5'd16: v = 33'sd16384;
      5'd17: v = 33'sd8192;
      5'd18: v = 33'sd4096;
      5'd19: v = 33'sd2048;
      5'd20: v = 33'sd1024;
      5'd21: v = 33'sd512;
      5'd22: v = 33'sd256;
      5'd23: v = 33'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [49:0] v);
    logic [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -50'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/sprite_mvp_matrix_builder.sv -----
// Top level of the 2D orthographic model-view-projection matrix builder.
// Throughput: one sprite per cycle while no scale divide is running, set by the 14-cell
// modulo chain, CORDIC cell chain and three-stage multiply path; a stalled result stalls
// the whole pipeline. A write to view_width, view_height or zoom_factor holds inputs
// while the serial dividers form the scale factors.
// Reset (rst_n, synchronous) clears valids and restores register defaults.
module sprite_mvp_matrix_builder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, angle, scale_x, scale_y
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // col0_row0, col0_row1, col1_row0, col1_row1, col3_row0, col3_row1
  output logic [191:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import smvp_pkg::*;

  localparam int L  = CORDIC_STEPS + 21;
  localparam int SL = CORDIC_STEPS + 18;

  logic signed [31:0] cam_x_r, cam_y_r;
  logic [30:0]        width_r, height_r, zoom_r;
  logic               start_r;
  logic               busy_x, busy_y, busy;
  logic [30:0]        sx, sy;
  logic               en;
  logic               cfg_wr;
  logic [L-1:0]       v_r;
  side_t              sd_r [SL];
  side_t              sd_in;
  logic [31:0]        a_r;
  logic [31:0]        red [RED_STAGES+1];
  logic signed [20:0] r0_r, r0_nxt, rc, rf;
  cordic_t            cord [CORDIC_STEPS+1];
  cordic_t            c0_nxt;
  cordic_t            c0_r;
  logic signed [19:0] c_r, s_r, c_nxt, s_nxt;
  logic signed [51:0] p_r [4];
  logic signed [32:0] dxm_r, dym_r;
  logic signed [33:0] im [4];
  logic signed [65:0] t_r [6];
  logic signed [31:0] sxs, sys;
  logic signed [49:0] rr [6];
  logic [191:0]       out_r;

  assign busy      = busy_x | busy_y | start_r;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en && !busy;
  assign cfg_ready = !busy;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r  <= '0;
      cam_y_r  <= '0;
      width_r  <= 31'd131072;
      height_r <= 31'd131072;
      zoom_r   <= 31'd65536;
      start_r  <= 1'b0;
    end else begin
      start_r <= cfg_wr &&
                 (cfg_index inside {CFG_VIEW_WIDTH, CFG_VIEW_HEIGHT, CFG_ZOOM_FACTOR});
      if (cfg_wr) begin
        case (cfg_index)
          CFG_CAMERA_X:    cam_x_r  <= cfg_data;
          CFG_CAMERA_Y:    cam_y_r  <= cfg_data;
          CFG_VIEW_WIDTH:  width_r  <= cfg_data[30:0];
          CFG_VIEW_HEIGHT: height_r <= cfg_data[30:0];
          CFG_ZOOM_FACTOR: zoom_r   <= cfg_data[30:0];
          default: ;
        endcase
      end
    end
  end

  smvp_div u_div_x (
    .clk(clk), .rst_n(rst_n), .start(start_r), .num({zoom_r, 17'd0}),
    .den((width_r == '0) ? 31'd1 : width_r), .busy(busy_x), .quo(sx)
  );

  smvp_div u_div_y (
    .clk(clk), .rst_n(rst_n), .start(start_r), .num({zoom_r, 17'd0}),
    .den((height_r == '0) ? 31'd1 : height_r), .busy(busy_y), .quo(sy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[L-2:0], in_tvalid && !busy};
    end
  end

  assign out_tvalid = v_r[L-1];

  always_comb begin
    sd_in.dx  = 33'($signed(in_tdata[31:0])) - 33'(cam_x_r);
    sd_in.dy  = 33'($signed(in_tdata[63:32])) - 33'(cam_y_r);
    sd_in.scx = $signed(in_tdata[127:96]);
    sd_in.scy = $signed(in_tdata[159:128]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r      <= in_tdata[95:64] ^ 32'h8000_0000;
      sd_r[0]  <= sd_in;
      for (int i = 1; i < SL; i++) begin
        sd_r[i] <= sd_r[i-1];
      end
    end
  end

  assign red[0] = a_r;

  for (genvar j = 0; j < RED_STAGES; j++) begin : g_red
    smvp_red_cell u_cell (
      .clk(clk), .en(en), .k(4'(RED_STAGES - 1 - j)), .d_i(red[j]), .d_o(red[j+1])
    );
  end

  always_comb begin
    r0_nxt = 21'(red[RED_STAGES]) - 21'(OFF_MOD);
    if (r0_nxt < 0) begin
      r0_nxt = r0_nxt + 21'(TWO_PI);
    end
    rc = (r0_r > $signed(21'(PI))) ? r0_r - 21'(TWO_PI) : r0_r;
    c0_nxt.x   = 33'(GAIN);
    c0_nxt.y   = '0;
    c0_nxt.neg = 1'b0;
    rf         = rc;
    if (rc > $signed(21'(HALF_PI))) begin
      rf         = rc - 21'(PI);
      c0_nxt.neg = 1'b1;
    end else if (rc < -$signed(21'(HALF_PI))) begin
      rf         = rc + 21'(PI);
      c0_nxt.neg = 1'b1;
    end
    c0_nxt.z = 33'(rf) <<< 14;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0_r <= r0_nxt;
      c0_r <= c0_nxt;
    end
  end

  assign cord[0] = c0_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    smvp_cordic_cell u_cell (
      .clk(clk), .en(en), .idx(5'(i)), .d_i(cord[i]), .d_o(cord[i+1])
    );
  end

  always_comb begin
    c_nxt = 20'((cord[CORDIC_STEPS].x + 33'sd8192) >>> 14);
    s_nxt = 20'((cord[CORDIC_STEPS].y + 33'sd8192) >>> 14);
    if (cord[CORDIC_STEPS].neg) begin
      c_nxt = -c_nxt;
      s_nxt = -s_nxt;
    end
    sxs = $signed({1'b0, sx});
    sys = $signed({1'b0, sy});
    for (int i = 0; i < 4; i++) begin
      im[i] = 34'((p_r[i] + 52'sd32768) >>> 16);
    end
    for (int i = 0; i < 6; i++) begin
      rr[i] = 50'((t_r[i] + 66'sd32768) >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r    <= c_nxt;
      s_r    <= s_nxt;
      p_r[0] <= c_r * sd_r[SL-1].scx;
      p_r[1] <= s_r * sd_r[SL-1].scx;
      p_r[2] <= (-s_r) * sd_r[SL-1].scy;
      p_r[3] <= c_r * sd_r[SL-1].scy;
      dxm_r  <= sd_r[SL-1].dx;
      dym_r  <= sd_r[SL-1].dy;
      t_r[0] <= im[0] * sxs;
      t_r[1] <= im[1] * sys;
      t_r[2] <= im[2] * sxs;
      t_r[3] <= im[3] * sys;
      t_r[4] <= dxm_r * sxs;
      t_r[5] <= dym_r * sys;
      out_r  <= {sat32(rr[5]), sat32(rr[4]), sat32(rr[3]),
                 sat32(rr[2]), sat32(rr[1]), sat32(rr[0])};
    end
  end

  assign out_tdata = out_r;

`include "sprite_mvp_matrix_builder_assert.svh"

  `SMVP_ASSERT_NEXT(a_scale_busy, start_r, busy_x && busy_y, "scale dividers not started")
  `SMVP_ASSERT_NEXT(a_accept_valid, in_tvalid && in_tready, v_r[0], "accepted item lost")
  `SMVP_ASSERT_NOW(a_no_accept_busy, busy_x || busy_y, !in_tready, "input taken during divide")

endmodule

// ----- rtl/smvp_red_cell.sv -----
// One conditional-subtract cell of the angle modulo chain.
module smvp_red_cell (
  input  logic        clk,
  input  logic        en,
  input  logic [3:0]  k,
  input  logic [31:0] d_i,
  output logic [31:0] d_o
);
  import smvp_pkg::*;

  logic [32:0] m_sh;
  logic [31:0] d_nxt;
  logic [31:0] d_r;

  always_comb begin
    m_sh = {14'd0, TWO_PI} << k;
    if ({1'b0, d_i} >= m_sh) begin
      d_nxt = d_i - m_sh[31:0];
    end else begin
      d_nxt = d_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;
endmodule

// ----- rtl/smvp_cordic_cell.sv -----
// One rotation cell of the CORDIC chain.
module smvp_cordic_cell (
  input  logic              clk,
  input  logic              en,
  input  logic [4:0]        idx,
  input  smvp_pkg::cordic_t d_i,
  output smvp_pkg::cordic_t d_o
);
  import smvp_pkg::*;

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] at;
  cordic_t              d_nxt;
  cordic_t              d_r;

  always_comb begin
    dx  = d_i.y >>> idx;
    dy  = d_i.x >>> idx;
    at  = atan_q30(idx);
    d_nxt.neg = d_i.neg;
    if (!d_i.z[ZW-1]) begin
      d_nxt.x = d_i.x - dx;
      d_nxt.y = d_i.y + dy;
      d_nxt.z = d_i.z - at;
    end else begin
      d_nxt.x = d_i.x + dx;
      d_nxt.y = d_i.y - dy;
      d_nxt.z = d_i.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;
endmodule

// ----- rtl/smvp_div.sv -----
// Serial restoring divider for the viewport scale factors.
module smvp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [30:0] den,
  output logic        busy,
  output logic [30:0] quo
);
  import smvp_pkg::*;

  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [47:0] n_r, n_nxt;
  logic [30:0] rem_r, rem_nxt;
  logic [47:0] q_r, q_nxt;
  logic [30:0] quo_r, quo_nxt;
  logic [31:0] trial;

  always_comb begin
    trial    = {rem_r, n_r[47]};
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    quo_nxt  = quo_r;
    if (start) begin
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      n_nxt    = num;
      rem_nxt  = '0;
      q_nxt    = '0;
    end else if (busy_r) begin
      n_nxt = {n_r[46:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem_nxt = 31'(trial - {1'b0, den});
        q_nxt   = {q_r[46:0], 1'b1};
      end else begin
        rem_nxt = trial[30:0];
        q_nxt   = {q_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(DIV_BITS - 1)) begin
        busy_nxt = 1'b0;
        quo_nxt  = (q_nxt[47:31] != '0) ? 31'h7FFF_FFFF : q_nxt[30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      quo_r  <= SCALE_RST;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      quo_r  <= quo_nxt;
    end
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign busy = busy_r;
  assign quo  = quo_r;
endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench of the sprite matrix builder: directed table plus random sprites.
`timescale 1ns / 100ps
module tb_top;
  import smvp_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [159:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [191:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;

  sprite_mvp_matrix_builder dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic [31:0] scale_y;
    logic [31:0] scale_x;
    logic [31:0] angle;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } sprite_t;

  typedef struct packed {
    logic [31:0] col3_row1;
    logic [31:0] col3_row0;
    logic [31:0] col1_row1;
    logic [31:0] col1_row0;
    logic [31:0] col0_row1;
    logic [31:0] col0_row0;
  } matrix_t;

  typedef struct {
    sprite_t s;
    bit      typed;
    matrix_t m;
  } table_row_t;

  logic signed [63:0] cam_x, cam_y;
  logic [63:0]        view_w, view_h, zoom;

  matrix_t pending_matrices[$];
  int      mismatches;
  int      checked;
  int      idle_cycles;
  bit      timed_out;
  bit      stim_done;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic signed [63:0] fshr(logic signed [63:0] v, int sh);
    return v >>> sh;
  endfunction

  function automatic logic signed [63:0] rshr(logic signed [63:0] v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] atan_entry(int i);
    logic signed [63:0] t[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
    return t[i];
  endfunction

  function automatic logic signed [63:0] view_scale(logic [63:0] z, logic [63:0] size);
    logic [63:0] d;
    logic [63:0] q;
    d = (size == 0) ? 64'd1 : size;
    q = (z << 17) / d;
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return $signed(q);
  endfunction

  function automatic matrix_t build_matrix(sprite_t s);
    logic signed [63:0] r, x, y, z, dx, dy, c, sn, sx, sy, px, py, scx, scy;
    bit flip;
    matrix_t m;
    px  = $signed(s.pos_x);
    py  = $signed(s.pos_y);
    scx = $signed(s.scale_x);
    scy = $signed(s.scale_y);
    r = $signed(s.angle) % 64'sd411775;
    flip = 0;
    if (r < 0) r += 411775;
    if (r > 205887) r -= 411775;
    if (r > 102944) begin
      r -= 205887; flip = 1;
    end else if (r < -102944) begin
      r += 205887; flip = 1;
    end
    x = 652032874; y = 0; z = r * 16384;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    c  = rshr(x, 14);
    sn = rshr(y, 14);
    if (flip) begin
      c = -c; sn = -sn;
    end
    sx = view_scale(zoom, view_w);
    sy = view_scale(zoom, view_h);
    m.col0_row0 = clamp32(rshr(rshr(c * scx, 16) * sx, 16));
    m.col0_row1 = clamp32(rshr(rshr(sn * scx, 16) * sy, 16));
    m.col1_row0 = clamp32(rshr(rshr(-sn * scy, 16) * sx, 16));
    m.col1_row1 = clamp32(rshr(rshr(c * scy, 16) * sy, 16));
    m.col3_row0 = clamp32(rshr((px - cam_x) * sx, 16));
    m.col3_row1 = clamp32(rshr((py - cam_y) * sy, 16));
    return m;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    case (idx)
      CFG_CAMERA_X:    cam_x  = $signed(val);
      CFG_CAMERA_Y:    cam_y  = $signed(val);
      CFG_VIEW_WIDTH:  view_w = {33'd0, val[30:0]};
      CFG_VIEW_HEIGHT: view_h = {33'd0, val[30:0]};
      CFG_ZOOM_FACTOR: zoom   = {33'd0, val[30:0]};
      default: ;
    endcase
  endtask

  task automatic set_camera(logic [31:0] cx, logic [31:0] cy, logic [31:0] w,
                            logic [31:0] h, logic [31:0] zf);
    while (pending_matrices.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    write_reg(CFG_CAMERA_X, cx);
    write_reg(CFG_CAMERA_Y, cy);
    write_reg(CFG_VIEW_WIDTH, w);
    write_reg(CFG_VIEW_HEIGHT, h);
    write_reg(CFG_ZOOM_FACTOR, zf);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_sprite(sprite_t s, bit typed, matrix_t m);
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_matrices.push_back(typed ? m : build_matrix(s));
    @(negedge clk);
  endtask

  task automatic maybe_gap(ref int burst);
    if (burst > 0) begin
      burst--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst = $urandom_range(0, 20);
    end
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 4))
      0: return 32'd1;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      default: return $urandom_range(1, 32'h0100_0000);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      matrix_t got, want;
      got = out_tdata;
      if (pending_matrices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected matrix %h", got);
      end else begin
        want = pending_matrices.pop_front();
        checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("matrix mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else case ($urandom_range(0, 7))
      0, 1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= (((checked / 64) % 3) != 2) || ($urandom_range(0, 1) != 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    table_row_t tbl[$];
    table_row_t row;
    sprite_t s;
    matrix_t zero_m;
    int burst;
    int phase;
    logic [31:0] f[5];
    f = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000};
    rst_n = 0; in_tvalid = 0; in_tdata = '0; cfg_valid = 0; cfg_index = CFG_CAMERA_X;
    cfg_data = '0; out_tready = 0; mismatches = 0; checked = 0; idle_cycles = 0;
    timed_out = 0; stim_done = 0;
    cam_x = 0; cam_y = 0; view_w = 131072; view_h = 131072; zoom = 65536;
    zero_m = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    repeat (60) @(negedge clk);

    // zero scale and position give an all-zero matrix
    row.typed = 1; row.s = '0; row.m = '0;
    tbl.push_back(row);
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 4; j++) begin
        row.typed = 0;
        row.s = {f[(i + j) % 5], f[(i + 2 * j) % 5], f[i], f[(j + 1) % 5], f[(i + 3) % 5]};
        tbl.push_back(row);
      end
    row.typed = 0; row.s = {32'h1, 32'h1, 32'd102945, 32'h5, 32'h5}; tbl.push_back(row);
    row.s = {32'h1, 32'h1, -32'd102945, 32'h5, 32'h5}; tbl.push_back(row);
    row.s = {32'h10000, 32'h10000, 32'd205887, 32'h0, 32'h0}; tbl.push_back(row);
    foreach (tbl[k]) send_sprite(tbl[k].s, tbl[k].typed, tbl[k].m);
    in_tvalid <= 1'b0;

    // zero zoom forces an all-zero matrix
    set_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0);
    send_sprite('{32'h7FFF_FFFF, 32'h8000_0000, 32'h1234, 32'h7FFF_FFFF, 32'h8000_0000},
                1, zero_m);
    in_tvalid <= 1'b0;
    set_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sprite('{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h10000, 32'h10000}, 0, zero_m);
    in_tvalid <= 1'b0;

    burst = 0;
    for (phase = 0; phase < 6; phase++) begin
      if (phase == 0) set_camera(32'h0, 32'h0, 32'h0002_0000, 32'h0002_0000, 32'h0001_0000);
      else set_camera(rand_field(), rand_field(), rand_size(), rand_size(), rand_size());
      for (int n = 0; n < 150; n++) begin
        s = {rand_field(), rand_field(), rand_field(), rand_field(), rand_field()};
        send_sprite(s, 0, zero_m);
        if (phase % 2 == 1) maybe_gap(burst);
      end
      in_tvalid <= 1'b0;
    end
    stim_done = 1;

    while (pending_matrices.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("Checked %0d matrices over directed extremes and six camera settings.", checked);
    if (mismatches == 0 && pending_matrices.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/smvp_pkg.sv
rtl/smvp_red_cell.sv
rtl/smvp_cordic_cell.sv
rtl/smvp_div.sv
rtl/sprite_mvp_matrix_builder.sv
sim/tb_top.sv
